// File: src/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants
// Sizes, entry layout and scan result record of the LFU cache table.
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int CAPACITY   = 16;
   localparam int COUNT_BITS = 16;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int CFG_BITS   = 5;

   localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int OCC_BITS = $clog2(CAPACITY + 1);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_ONE  = COUNT_BITS'(1);
   localparam logic [VALUE_BITS-1:0] MISS_VALUE = {VALUE_BITS{1'b1}};
   localparam logic [CFG_BITS-1:0]   LIVE_RESET = CFG_BITS'(16);

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
      logic [COUNT_BITS-1:0] count;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   // one entry as it leaves the table during a scan
   typedef struct packed {
      logic                live;
      logic [IDX_BITS-1:0] idx;
      logic [IDX_BITS-1:0] rank;
      entry_type           data;
   } scan_entry_type;

   typedef struct packed {
      logic                  found;
      logic [IDX_BITS-1:0]   found_idx;
      logic [IDX_BITS-1:0]   found_rank;
      entry_type             found_data;
      logic                  victim_ok;
      logic [IDX_BITS-1:0]   victim_idx;
      logic [IDX_BITS-1:0]   victim_rank;
      logic [COUNT_BITS-1:0] victim_count;
      logic                  free_ok;
      logic [IDX_BITS-1:0]   free_idx;
   } scan_result_type;

endpackage

// File: src/lfu_ram.sv
// ----------------------------------------------------------------------------
// lfu_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/lfu_scan.sv
// ----------------------------------------------------------------------------
// lfu_scan: key match and victim search
// Folds the entries streamed out of the table into the first key match,
// the least-used, least-recent victim and the first free slot.
// ----------------------------------------------------------------------------
module lfu_scan (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  clear,
   input  logic                                  strobe,
   input  lfu_pkg::scan_entry_type               entry,
   input  logic [lfu_pkg::KEY_BITS-1:0]          lookup_key,
   output lfu_pkg::scan_result_type              result
);

   lfu_pkg::scan_result_type res_ff;
   lfu_pkg::scan_result_type res_in;

   always_comb begin
      res_in = res_ff;
      if (clear) begin
         res_in.found     = 1'b0;
         res_in.victim_ok = 1'b0;
         res_in.free_ok   = 1'b0;
      end else if (strobe) begin
         if (entry.live) begin
            if (!res_ff.found && entry.data.key == lookup_key) begin
               res_in.found      = 1'b1;
               res_in.found_idx  = entry.idx;
               res_in.found_rank = entry.rank;
               res_in.found_data = entry.data;
            end
            if (!res_ff.victim_ok || entry.data.count < res_ff.victim_count ||
                (entry.data.count == res_ff.victim_count &&
                 entry.rank < res_ff.victim_rank)) begin
               res_in.victim_ok    = 1'b1;
               res_in.victim_idx   = entry.idx;
               res_in.victim_rank  = entry.rank;
               res_in.victim_count = entry.data.count;
            end
         end else if (!res_ff.free_ok) begin
            res_in.free_ok  = 1'b1;
            res_in.free_idx = entry.idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= '0;
      end else begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

// File: src/lfu_cache_table_top.sv
// ----------------------------------------------------------------------------
// lfu_cache_table_top: LFU key/value cache with LRU tie break
// Items are taken one at a time: req_stall is high from the accept until the
// write-back finishes. Each item is scanned with sixteen reads through the
// single registered read port of the entry RAM, then written back in the write
// state, which holds while a previous result still stalls the output; the next
// item is taken in the idle state. rsp_valid is set as the write state ends.
// Reset: synchronous, active high; clears valid bits, occupancy, the result
// valid flag and sets live capacity to 16. No clearing pass is needed.
// ----------------------------------------------------------------------------
module lfu_cache_table_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_cmd,
   input  logic signed [lfu_pkg::KEY_BITS-1:0]     req_lookup_key,
   input  logic signed [lfu_pkg::VALUE_BITS-1:0]   req_write_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_hit,
   output logic signed [lfu_pkg::VALUE_BITS-1:0]   rsp_read_value,
   input  logic                                    csr_wr_en,
   input  logic [lfu_pkg::CFG_BITS-1:0]            csr_wr_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;

   logic [1:0]                       state_ff, state_in;
   logic [lfu_pkg::OCC_BITS-1:0]     cnt_ff, cnt_in;
   logic                             pend_ff;
   logic [lfu_pkg::IDX_BITS-1:0]     pidx_ff;
   logic                             cmd_ff;
   logic [lfu_pkg::KEY_BITS-1:0]     key_ff;
   logic [lfu_pkg::VALUE_BITS-1:0]   val_ff;
   logic [lfu_pkg::CFG_BITS-1:0]     live_ff;
   logic [lfu_pkg::OCC_BITS-1:0]     occ_ff, occ_in;
   logic [lfu_pkg::CAPACITY-1:0]     valid_ff, valid_in;
   logic [lfu_pkg::IDX_BITS-1:0]     rank_ff [lfu_pkg::CAPACITY];
   logic [lfu_pkg::IDX_BITS-1:0]     rank_in [lfu_pkg::CAPACITY];
   logic                             rsp_valid_ff;
   logic                             rsp_hit_ff;
   logic [lfu_pkg::VALUE_BITS-1:0]   rsp_value_ff;

   logic                             accept;
   logic                             rd_en;
   logic [lfu_pkg::ENTRY_BITS-1:0]   rd_data;
   lfu_pkg::scan_entry_type          scan_entry;
   lfu_pkg::scan_result_type         res;

   logic [lfu_pkg::OCC_BITS-1:0]     cap;
   logic                             can_go;
   logic                             finish;
   logic                             do_touch, put_miss, evict, fill;
   logic                             wr_en, unlink_en;
   logic [lfu_pkg::IDX_BITS-1:0]     wr_idx, unlink_rank, new_rank;
   lfu_pkg::entry_type               wr_data;
   logic [lfu_pkg::COUNT_BITS-1:0]   inc_count;

   assign accept    = (state_ff == ST_IDLE) && req_valid;
   assign req_stall = (state_ff != ST_IDLE);
   assign rd_en     = (state_ff == ST_SCAN) && (cnt_ff < lfu_pkg::OCC_BITS'(lfu_pkg::CAPACITY));

   lfu_ram #(
      .WIDTH (lfu_pkg::ENTRY_BITS),
      .DEPTH (lfu_pkg::CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff[lfu_pkg::IDX_BITS-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      scan_entry.live = valid_ff[pidx_ff];
      scan_entry.idx  = pidx_ff;
      scan_entry.rank = rank_ff[pidx_ff];
      scan_entry.data = lfu_pkg::entry_type'(rd_data);
   end

   lfu_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .clear      (accept),
      .strobe     (pend_ff),
      .entry      (scan_entry),
      .lookup_key (key_ff),
      .result     (res)
   );

   // effective capacity is the live setting clamped to the table size
   always_comb begin
      if (32'(live_ff) < lfu_pkg::CAPACITY) begin
         cap = lfu_pkg::OCC_BITS'(live_ff);
      end else begin
         cap = lfu_pkg::OCC_BITS'(lfu_pkg::CAPACITY);
      end
   end

   assign can_go = !rsp_valid_ff || !rsp_stall;
   assign finish = (state_ff == ST_WRITE) && can_go;

   assign do_touch = res.found && (cmd_ff == lfu_pkg::CMD_GET || cap != '0);
   assign put_miss = (cmd_ff == lfu_pkg::CMD_PUT) && (cap != '0) && !res.found;
   assign evict    = put_miss && (occ_ff >= cap) && res.victim_ok;
   assign fill     = put_miss && (occ_ff < cap) && res.free_ok;

   assign wr_en     = finish && (do_touch || evict || fill);
   assign unlink_en = finish && (do_touch || evict);
   assign inc_count = (res.found_data.count == lfu_pkg::COUNT_MAX) ?
                      res.found_data.count : res.found_data.count + 1'b1;

   always_comb begin
      if (do_touch) begin
         wr_idx        = res.found_idx;
         unlink_rank   = res.found_rank;
         wr_data.key   = key_ff;
         wr_data.value = (cmd_ff == lfu_pkg::CMD_PUT) ? val_ff : res.found_data.value;
         wr_data.count = inc_count;
      end else begin
         wr_idx        = evict ? res.victim_idx : res.free_idx;
         unlink_rank   = res.victim_rank;
         wr_data.key   = key_ff;
         wr_data.value = val_ff;
         wr_data.count = lfu_pkg::COUNT_ONE;
      end
   end

   assign occ_in   = (finish && fill) ? occ_ff + 1'b1 : occ_ff;
   assign new_rank = lfu_pkg::IDX_BITS'(occ_in - 1'b1);

   always_comb begin
      valid_in = valid_ff;
      for (int i = 0; i < lfu_pkg::CAPACITY; i++) begin
         rank_in[i] = rank_ff[i];
         // close the gap left by the entry that moves to the top
         if (unlink_en && valid_ff[i] && lfu_pkg::IDX_BITS'(i) != wr_idx &&
             rank_ff[i] > unlink_rank) begin
            rank_in[i] = rank_ff[i] - 1'b1;
         end
         if (wr_en && lfu_pkg::IDX_BITS'(i) == wr_idx) begin
            rank_in[i]  = new_rank;
            valid_in[i] = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               cnt_in = cnt_ff + 1'b1;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (can_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         live_ff      <= lfu_pkg::LIVE_RESET;
         occ_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= rd_en;
         occ_ff   <= occ_in;
         valid_ff <= valid_in;
         if (csr_wr_en) begin
            live_ff <= csr_wr_data;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff <= cnt_ff[lfu_pkg::IDX_BITS-1:0];
      rank_ff <= rank_in;
      if (accept) begin
         cmd_ff <= req_cmd;
         key_ff <= req_lookup_key;
         val_ff <= req_write_value;
      end
      if (finish) begin
         rsp_hit_ff   <= res.found;
         rsp_value_ff <= res.found ? res.found_data.value : lfu_pkg::MISS_VALUE;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;

endmodule

// File: src/lfu_checker.sv
// ----------------------------------------------------------------------------
// lfu_checker: port-level checks for the LFU cache table
// Watches the top-level handshakes over time; bound to the top level.
// ----------------------------------------------------------------------------
module lfu_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_stall,
   input logic                                    rsp_valid,
   input logic                                    rsp_stall,
   input logic                                    rsp_hit,
   input logic signed [lfu_pkg::VALUE_BITS-1:0]   rsp_read_value
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_read_value))
      else $error("stalled result changed");

   // one item at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while an item is in flight");

   // no result can appear the cycle after an accept
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (!rsp_valid || !rsp_stall) |=> !rsp_valid)
      else $error("result appeared too early");

   // the block is ready again when a new result shows up
   a_ready_with_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall)
      else $error("not ready when result was presented");

endmodule

bind lfu_cache_table_top lfu_checker u_checker (.*);
